FILE: sv/lsbd_pkg.sv
// ----------------------------------------------------------------------------
// lsbd_pkg
// Shared types and constants for the Lehmer stream bank.
// ----------------------------------------------------------------------------
package lsbd_pkg;

  localparam int SEED_W  = 31;
  localparam int MOD_W   = 32;
  localparam int PROD_W  = 62;
  localparam int DRAW_W  = 20;
  localparam int KIND_W  = 3;
  localparam int SETI_W  = 4;
  localparam int STRI_W  = 5;
  localparam int SEND_W  = 4;
  localparam int RETRY_W = 5;
  localparam int IN_W    = 56;
  localparam int OUT_W   = 56;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD     = 3'd0,
    KIND_STEP     = 3'd1,
    KIND_XMIT     = 3'd2,
    KIND_BACKOFF  = 3'd3,
    KIND_PERCENT  = 3'd4,
    KIND_NEXT_SET = 3'd5,
    KIND_RSVD6    = 3'd6,
    KIND_RSVD7    = 3'd7
  } kind_t;

  localparam logic [SEED_W-1:0] XMIT_RANGE    = 31'd10;
  localparam logic [SEED_W-1:0] PERCENT_RANGE = 31'd100;
  localparam logic [SEED_W-1:0] MULT_RESET    = 31'd16807;
  localparam logic [SEED_W-1:0] MOD_RESET     = 31'h7FFF_FFFF;

  localparam logic [0:0] REG_MULT = 1'b0;
  localparam logic [0:0] REG_MOD  = 1'b1;

  typedef struct packed {
    logic              done;
    logic [MOD_W-1:0]  rem;
    logic [DRAW_W-1:0] quo;
  } mdu_res_t;

endpackage

FILE: sv/lsbd_ram.sv
// ----------------------------------------------------------------------------
// lsbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsbd_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/lsbd_mdu.sv
// ----------------------------------------------------------------------------
// lsbd_mdu
// Shared multiply-divide unit: forms a*b, then restoring division by the
// modulus one bit per cycle; returns remainder and low quotient bits.
// ----------------------------------------------------------------------------
module lsbd_mdu
  import lsbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SEED_W-1:0] op_a,
  input  logic [SEED_W-1:0] op_b,
  input  logic [MOD_W-1:0]  divisor,
  output mdu_res_t          res
);

  logic [PROD_W-1:0] prod_r;
  logic [MOD_W-1:0]  rem_r, rem_nxt;
  logic [DRAW_W-1:0] quo_r;
  logic [MOD_W-1:0]  div_r;
  logic [5:0]        cnt_r;
  logic              busy_r, done_r;
  logic [MOD_W:0]    trial;
  logic              fits;

  always_comb begin
    trial   = {rem_r, prod_r[PROD_W-1]};
    fits    = trial >= {1'b0, div_r};
    rem_nxt = fits ? MOD_W'(trial - {1'b0, div_r}) : trial[MOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(PROD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PROD_W'({{SEED_W{1'b0}}, op_a} * {{SEED_W{1'b0}}, op_b});
      rem_r  <= '0;
      quo_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      prod_r <= {prod_r[PROD_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[DRAW_W-2:0], fits};
    end
  end

  assign res.done = done_r;
  assign res.rem  = rem_r;
  assign res.quo  = quo_r;

endmodule

FILE: sv/lehmer_stream_bank_draws.sv
// ----------------------------------------------------------------------------
// lehmer_stream_bank_draws
// Bank of Lehmer generators in sets, with scaled draws.
// ----------------------------------------------------------------------------
// One command beat at a time. Every stream step and every scaled draw runs
// on one shared multiply-divide unit: a product, then the bit-serial
// division by the modulus. A stream step first reads the seed from the RAM.
// Seed load, next set and unknown kinds use no step; a raw step uses one;
// transmit time and percent use a step and a draw; backoff uses two steps,
// two draws and a final product. A new command is taken while a finished
// result still waits on the output. Seeds sit in a RAM of
// STREAM_SETS*STREAMS_PER_SET entries, undefined until loaded.
module lehmer_stream_bank_draws
  import lsbd_pkg::*;
#(
  parameter int STREAM_SETS        = 16,
  parameter int STREAMS_PER_SET    = 32,
  parameter int MAX_RETRY_EXPONENT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // kind[2:0], set_index[6:3], stream_index[11:7], seed_value[42:12],
  // sender[46:43], retry_exponent[51:47], zero pad
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // stream_value[30:0], draw_value[50:31], zero pad
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int DEPTH = STREAM_SETS * STREAMS_PER_SET;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (STREAM_SETS > 1) ? $clog2(STREAM_SETS) : 1;
  localparam int TW    = $clog2(STREAMS_PER_SET);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_STEP_GO, S_STEP_WAIT, S_SCALE_GO, S_SCALE_WAIT, S_PROD, S_OUT
  } state_t;

  function automatic logic [SW-1:0] set_wrap(input logic [SETI_W-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << SETI_W); i++) begin
      if (v == SETI_W'(i)) r = SW'(i % STREAM_SETS);
    end
    return r;
  endfunction

  function automatic logic [TW-1:0] stream_wrap(input logic [5:0] v);
    logic [TW-1:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (v == 6'(i)) r = TW'(i % STREAMS_PER_SET);
    end
    return r;
  endfunction

  logic [SEED_W-1:0] mult_r, mod_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= MULT_RESET;
      mod_r  <= MOD_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_MULT: mult_r <= cfg_pwdata[SEED_W-1:0];
        REG_MOD:  mod_r  <= cfg_pwdata[SEED_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MULT: cfg_prdata = {1'b0, mult_r};
      REG_MOD:  cfg_prdata = {1'b0, mod_r};
      default:  cfg_prdata = '0;
    endcase
  end

  kind_t               in_kind;
  logic [SETI_W-1:0]   in_set;
  logic [STRI_W-1:0]   in_stream;
  logic [SEED_W-1:0]   in_seed;
  logic [SEND_W-1:0]   in_sender;
  logic [RETRY_W-1:0]  in_retry;

  assign in_kind   = kind_t'(in_tdata[2:0]);
  assign in_set    = in_tdata[6:3];
  assign in_stream = in_tdata[11:7];
  assign in_seed   = in_tdata[42:12];
  assign in_sender = in_tdata[46:43];
  assign in_retry  = in_tdata[51:47];

  state_t            state_r;
  kind_t             kind_r;
  logic              phase_r;
  logic [SW-1:0]     active_r;
  logic [TW-1:0]     stream_r;
  logic [SEED_W-1:0] k_r;
  logic [SEED_W-1:0] win_r;
  logic [SEED_W-1:0] sval_r;
  logic [DRAW_W-1:0] dval_r;
  logic [3:0]        t_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic              accept;
  logic [RETRY_W-1:0] r_sat;
  logic [SEED_W-1:0] window;
  logic [MOD_W-1:0]  eff_mod;
  logic              mdu_start;
  logic [SEED_W-1:0] mdu_a, mdu_b;
  mdu_res_t          mdu_res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr, step_addr;
  logic [SEED_W-1:0] ram_wdata, ram_rdata;
  logic [SEED_W-1:0] new_seed;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign r_sat   = (in_retry > RETRY_W'(MAX_RETRY_EXPONENT)) ?
                   RETRY_W'(MAX_RETRY_EXPONENT) : in_retry;
  assign window  = SEED_W'((32'd1 << r_sat) - 32'd1);
  assign eff_mod = (mod_r == '0) ? (MOD_W'(1) << SEED_W) : {1'b0, mod_r};

  assign step_addr = AW'(AW'(active_r) * AW'(STREAMS_PER_SET) + AW'(stream_r));
  assign ram_raddr = step_addr;
  assign new_seed  = mdu_res.rem[SEED_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = step_addr;
    ram_wdata = new_seed;
    if (accept && in_kind == KIND_LOAD) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(AW'(set_wrap(in_set)) * AW'(STREAMS_PER_SET)
                      + AW'(stream_wrap({1'b0, in_stream})));
      ram_wdata = in_seed;
    end else if (state_r == S_STEP_WAIT && mdu_res.done) begin
      ram_we = 1'b1;
    end
  end

  assign mdu_start = (state_r == S_STEP_GO) || (state_r == S_SCALE_GO);
  assign mdu_a     = (state_r == S_STEP_GO) ? ram_rdata : sval_r;
  assign mdu_b     = (state_r == S_STEP_GO) ? mult_r : k_r;

  lsbd_ram #(.WIDTH(SEED_W), .DEPTH(DEPTH)) u_seed_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lsbd_mdu u_mdu (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mdu_start),
    .op_a    (mdu_a),
    .op_b    (mdu_b),
    .divisor (eff_mod),
    .res     (mdu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r  <= in_kind;
            phase_r <= 1'b0;
            dval_r  <= '0;
            unique case (in_kind)
              KIND_LOAD: begin
                sval_r  <= in_seed;
                state_r <= S_OUT;
              end
              KIND_STEP: begin
                stream_r <= stream_wrap({1'b0, in_stream});
                state_r  <= S_READ;
              end
              KIND_XMIT: begin
                stream_r <= stream_wrap(6'd2 + {1'b0, in_sender, 1'b0});
                k_r      <= XMIT_RANGE;
                state_r  <= S_READ;
              end
              KIND_BACKOFF: begin
                stream_r <= stream_wrap(6'd2 + {1'b0, in_sender, 1'b0});
                k_r      <= XMIT_RANGE;
                t_r      <= '0;
                win_r    <= window;
                state_r  <= S_READ;
              end
              KIND_PERCENT: begin
                stream_r <= stream_wrap(6'd1);
                k_r      <= PERCENT_RANGE;
                state_r  <= S_READ;
              end
              KIND_NEXT_SET: begin
                active_r <= (active_r == SW'(STREAM_SETS - 1)) ? '0 : active_r + SW'(1);
                sval_r   <= '0;
                state_r  <= S_OUT;
              end
              default: begin
                sval_r  <= '0;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_READ:    state_r <= S_STEP_GO;
        S_STEP_GO: state_r <= S_STEP_WAIT;
        S_STEP_WAIT: begin
          if (mdu_res.done) begin
            sval_r  <= new_seed;
            state_r <= (kind_r == KIND_STEP) ? S_OUT : S_SCALE_GO;
          end
        end
        S_SCALE_GO: state_r <= S_SCALE_WAIT;
        S_SCALE_WAIT: begin
          if (mdu_res.done) begin
            if (kind_r == KIND_XMIT) begin
              dval_r  <= mdu_res.quo + DRAW_W'(1);
              state_r <= S_OUT;
            end else if (kind_r == KIND_PERCENT) begin
              dval_r  <= mdu_res.quo;
              state_r <= S_OUT;
            end else if (!phase_r) begin
              t_r      <= 4'(mdu_res.quo + DRAW_W'(1));
              k_r      <= win_r;
              phase_r  <= 1'b1;
              stream_r <= stream_wrap(6'd0);
              state_r  <= S_READ;
            end else begin
              dval_r  <= mdu_res.quo;
              state_r <= S_PROD;
            end
          end
        end
        S_PROD: begin
          dval_r  <= DRAW_W'({4'd0, dval_r} * {{DRAW_W{1'b0}}, t_r});
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= OUT_W'({dval_r, sval_r});
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/lsbd_checker.sv
// ----------------------------------------------------------------------------
// lsbd_checker
// Port-level checks on the Lehmer stream bank, bound to the top level.
// ----------------------------------------------------------------------------
module lsbd_checker
  import lsbd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             cfg_pready
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command taken while previous still in work");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result beat appeared too early");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("config port stalled");

endmodule

bind lehmer_stream_bank_draws lsbd_checker u_lsbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

FILE: test/lehmer_stream_bank_draws_tb.sv
// ----------------------------------------------------------------------------
// lehmer_stream_bank_draws_tb
// Self-checking bench for the Lehmer stream bank: command beats go in from a
// queue, an internal predictor of the seed bank forms the expected result of
// each accepted beat, and every result beat is checked field by field.
// ----------------------------------------------------------------------------
module lehmer_stream_bank_draws_tb
  import lsbd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS      = 16;
  localparam int PER_SET   = 32;
  localparam int MAX_RETRY = 16;
  localparam int BANK      = SETS * PER_SET;
  localparam int IDLE_PCT  = 21;
  localparam int WATCHDOG  = 4000;
  localparam int HOLD_LEN  = 400;
  localparam logic [2:0] ADDR_MULT = 3'd0;
  localparam logic [2:0] ADDR_MOD  = 3'd4;

  typedef struct packed {
    logic [RETRY_W-1:0] retry;
    logic [SEND_W-1:0]  sender;
    logic [SEED_W-1:0]  seed;
    logic [STRI_W-1:0]  stream;
    logic [SETI_W-1:0]  set_idx;
    kind_t              kind;
  } command_t;

  typedef struct packed {
    logic [DRAW_W-1:0] draw;
    logic [SEED_W-1:0] stream_val;
  } draw_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid, in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  lehmer_stream_bank_draws uut (.*);

  command_t  pending_cmds[$];
  draw_res_t expected_draws[$];
  int errors;
  int in_count, out_count;
  bit hold_done;
  int hold_left;

  logic [SEED_W-1:0] bank_seed[BANK];
  logic [SETI_W-1:0] bank_active;
  logic [SEED_W-1:0] cur_mult, cur_mod;

  bit                gen_loaded[BANK];
  logic [SETI_W-1:0] gen_active;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] eff_mod();
    return (cur_mod == '0) ? 64'h8000_0000 : {33'd0, cur_mod};
  endfunction

  function automatic logic [SEED_W-1:0] step_stream(int idx);
    int slot;
    logic [63:0] prod;
    slot = int'(bank_active) * PER_SET + (idx % PER_SET);
    prod = {33'd0, bank_seed[slot]} * {33'd0, cur_mult};
    bank_seed[slot] = SEED_W'(prod % eff_mod());
    return bank_seed[slot];
  endfunction

  function automatic logic [63:0] scaled(logic [SEED_W-1:0] s, logic [63:0] k);
    return ({33'd0, s} * k) / eff_mod();
  endfunction

  function automatic draw_res_t predict_draw(command_t c);
    draw_res_t r;
    logic [63:0] t, w, win;
    int e;
    r = '0;
    case (c.kind)
      KIND_LOAD: begin
        bank_seed[int'(c.set_idx) * PER_SET + int'(c.stream)] = c.seed;
        r.stream_val = c.seed;
      end
      KIND_STEP: r.stream_val = step_stream(int'(c.stream));
      KIND_XMIT: begin
        r.stream_val = step_stream(2 + 2 * int'(c.sender));
        r.draw = DRAW_W'(scaled(r.stream_val, 64'd10) + 1);
      end
      KIND_BACKOFF: begin
        e = (int'(c.retry) > MAX_RETRY) ? MAX_RETRY : int'(c.retry);
        win = (64'd1 << e) - 1;
        t = scaled(step_stream(2 + 2 * int'(c.sender)), 64'd10) + 1;
        r.stream_val = step_stream(0);
        w = scaled(r.stream_val, win);
        r.draw = DRAW_W'(t * w);
      end
      KIND_PERCENT: begin
        r.stream_val = step_stream(1);
        r.draw = DRAW_W'(scaled(r.stream_val, 64'd100));
      end
      KIND_NEXT_SET: bank_active = bank_active + 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [SEED_W-1:0] rand_seed();
    case ($urandom_range(9))
      0: return 31'd1;
      1: return 31'h7FFF_FFFE;
      2: return 31'h7FFF_FFFF;
      3: return 31'd0;
      default: return SEED_W'($urandom);
    endcase
  endfunction

  // queue a beat, turning a step or draw on an unloaded stream into a load of it
  task automatic push_cmd(command_t c);
    int need[2];
    int n;
    n = 0;
    case (c.kind)
      KIND_STEP: begin need[0] = int'(c.stream); n = 1; end
      KIND_XMIT: begin need[0] = (2 + 2 * int'(c.sender)) % PER_SET; n = 1; end
      KIND_BACKOFF: begin
        need[0] = (2 + 2 * int'(c.sender)) % PER_SET; need[1] = 0; n = 2;
      end
      KIND_PERCENT: begin need[0] = 1; n = 1; end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      if (!gen_loaded[int'(gen_active) * PER_SET + need[i]]) begin
        c.kind    = KIND_LOAD;
        c.set_idx = gen_active;
        c.stream  = STRI_W'(need[i]);
        break;
      end
    end
    if (c.kind == KIND_LOAD) gen_loaded[int'(c.set_idx) * PER_SET + int'(c.stream)] = 1'b1;
    if (c.kind == KIND_NEXT_SET) gen_active = gen_active + 1'b1;
    pending_cmds.push_back(c);
  endtask

  task automatic push_random();
    command_t c;
    int pick;
    c.set_idx = SETI_W'($urandom);
    c.stream  = STRI_W'($urandom);
    c.seed    = rand_seed();
    c.sender  = SEND_W'($urandom);
    c.retry   = RETRY_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 10)      c.kind = KIND_LOAD;
    else if (pick < 28) c.kind = KIND_STEP;
    else if (pick < 48) c.kind = KIND_XMIT;
    else if (pick < 68) c.kind = KIND_BACKOFF;
    else if (pick < 88) c.kind = KIND_PERCENT;
    else if (pick < 94) c.kind = KIND_NEXT_SET;
    else if (pick < 97) c.kind = KIND_RSVD6;
    else                c.kind = KIND_RSVD7;
    push_cmd(c);
  endtask

  task automatic push_directed(kind_t k, int set_idx, int stream, logic [SEED_W-1:0] seed,
                               int sender, int retry);
    command_t c;
    c.kind = k; c.set_idx = SETI_W'(set_idx); c.stream = STRI_W'(stream);
    c.seed = seed; c.sender = SEND_W'(sender); c.retry = RETRY_W'(retry);
    push_cmd(c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_tvalid || expected_draws.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= addr; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == ADDR_MULT) cur_mult = value[SEED_W-1:0];
    else                   cur_mod  = value[SEED_W-1:0];
  endtask

  task automatic set_regs(logic [31:0] mult, logic [31:0] modv);
    wait_drained();
    repeat (20) @(posedge clk);
    write_reg(ADDR_MULT, mult);
    write_reg(ADDR_MOD, modv);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_draws.push_back(predict_draw(command_t'(in_tdata[$bits(command_t)-1:0])));
        in_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() != 0 &&
            (($urandom_range(99) >= IDLE_PCT) || (in_count > 300 && in_count < 450))) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_W'(pending_cmds.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    draw_res_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = draw_res_t'(out_tdata[SEED_W+DRAW_W-1:0]);
        out_count++;
        if (expected_draws.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", out_tdata);
        end else begin
          want = expected_draws.pop_front();
          if (got !== want || out_tdata[OUT_W-1:SEED_W+DRAW_W] !== '0) begin
            errors++;
            if (errors <= 10)
              $display("beat %0d: stream_value exp %h got %h, draw_value exp %h got %h",
                       out_count, want.stream_val, got.stream_val, want.draw, got.draw);
          end
        end
      end
      if (!hold_done && out_count == 500) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT) || (out_count > 300 && out_count < 450);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG) begin
        $display("lehmer_stream_bank_draws verification failed");
        $finish;
      end
    end
  end

  initial begin
    errors = 0; in_count = 0; out_count = 0;
    hold_done = 1'b0; hold_left = 0;
    foreach (bank_seed[i]) bank_seed[i] = '0;
    foreach (gen_loaded[i]) gen_loaded[i] = 1'b0;
    bank_active = '0; gen_active = '0;
    cur_mult = MULT_RESET; cur_mod = MOD_RESET;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    push_directed(KIND_LOAD, 0, 0, 31'd1, 0, 0);
    push_directed(KIND_LOAD, 0, 1, 31'h7FFF_FFFE, 0, 0);
    push_directed(KIND_LOAD, 0, 2, 31'h7FFF_FFFF, 0, 0);
    push_directed(KIND_LOAD, 15, 31, 31'h1234_5678, 0, 0);
    push_directed(KIND_STEP, 0, 2, 0, 0, 0);
    push_directed(KIND_STEP, 0, 0, 0, 0, 0);
    push_directed(KIND_XMIT, 0, 0, 0, 0, 0);
    push_directed(KIND_XMIT, 0, 0, 0, 15, 0);
    push_directed(KIND_BACKOFF, 0, 0, 0, 0, 0);
    push_directed(KIND_BACKOFF, 0, 0, 0, 0, 16);
    push_directed(KIND_BACKOFF, 0, 0, 0, 15, 31);
    push_directed(KIND_BACKOFF, 0, 0, 0, 14, 17);
    push_directed(KIND_PERCENT, 0, 0, 0, 0, 0);
    push_directed(KIND_RSVD6, 15, 31, 31'h7FFF_FFFF, 15, 31);
    push_directed(KIND_RSVD7, 0, 0, 0, 0, 0);
    push_directed(KIND_NEXT_SET, 0, 0, 0, 0, 0);
    push_directed(KIND_LOAD, 1, 31, 31'h7FFF_FFFF, 0, 0);
    push_directed(KIND_STEP, 0, 31, 0, 0, 0);
    push_directed(KIND_PERCENT, 0, 0, 0, 0, 0);
    repeat (170) push_random();

    // hold input until all results are back
    wait_drained();
    repeat (20) push_random();

    set_regs(32'd48271, 32'h7FFF_FFFF);
    repeat (190) push_random();
    set_regs(32'd2, 32'd3);
    repeat (190) push_random();
    set_regs(32'h7FFF_FFFE, 32'd0);
    repeat (190) push_random();
    set_regs(32'hFFFF_FFFF, 32'd1000);
    repeat (190) push_random();

    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_draws.size() == 0)
      $display("lehmer_stream_bank_draws verification clean");
    else
      $display("lehmer_stream_bank_draws verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/lsbd_pkg.sv
sv/lsbd_ram.sv
sv/lsbd_mdu.sv
sv/lehmer_stream_bank_draws.sv
sv/lsbd_checker.sv
test/lehmer_stream_bank_draws_tb.sv
